@@ hw/rtl/double_ended_queue_defines.svh @@
// Assertion macros used by double_ended_queue.sv.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DEQ_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`define DEQ_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define DEQ_ASSERT_NOW(label, clk, rst, cond, expr)
`define DEQ_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

@@ hw/rtl/deq_pkg.sv @@
`default_nettype none

package deq_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 11;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_QUERY      = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]               cmd;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic                     pop_valid;
      logic [1:0]               status;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/deq_store.sv @@
`default_nettype none

module deq_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [deq_pkg::DATA_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [deq_pkg::DATA_W-1:0] rd_data
);

   logic [deq_pkg::DATA_W-1:0] store_ff [DEPTH];
   logic [deq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/double_ended_queue.sv @@
// Channel  Direction  Beat payload        Handshake
// req      in         deq_pkg::req_type   req_valid / req_stall
// rsp      out        deq_pkg::rsp_type   rsp_valid / rsp_stall
//
// Push, query, a pop on an empty queue and a pop that empties it register
// their result directly. Any other pop first reads the new front or back entry
// back from the element memory (registered read), then registers its result.
// Synchronous reset empties the queue; memory contents are not cleared.
// A stalled result holds in the output register; req_stall rises only
// while that register is blocked or a memory read-back is in flight.
`default_nettype none

`include "double_ended_queue_defines.svh"

module double_ended_queue #(
   parameter int DEPTH = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire deq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output deq_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX   = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FILL = 1'b1;

   function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   logic                          state_ff, state_in;
   logic                          fill_front_ff, fill_front_in;
   logic [AW-1:0]                 fp_ff, fp_in;
   logic [AW-1:0]                 bp_ff, bp_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [deq_pkg::DATA_W-1:0]    front_ff, front_in;
   logic [deq_pkg::DATA_W-1:0]    back_ff, back_in;
   logic [deq_pkg::DATA_W-1:0]    popped_ff, popped_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   logic [deq_pkg::DATA_W-1:0]    rd_data;

   logic                          slot_free;
   logic                          req_fire;
   logic                          q_empty;
   logic                          q_full;
   logic                          is_pop;
   logic [AW-1:0]                 fp_inc, fp_dec, bp_inc, bp_dec, bp_dec2;
   logic                          load_rsp;
   logic [1:0]                    out_status;
   logic [deq_pkg::DATA_W-1:0]    out_popped;
   logic                          out_pop_valid;
   logic                          out_empty;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !slot_free;
   assign req_fire  = req_valid && !req_stall;
   assign q_empty   = (count_ff == '0);
   assign q_full    = (count_ff == FULL_COUNT);
   assign is_pop    = (req_data.cmd == deq_pkg::CMD_POP_FRONT)
                   || (req_data.cmd == deq_pkg::CMD_POP_BACK);
   assign fp_inc    = idx_next(fp_ff);
   assign fp_dec    = idx_prev(fp_ff);
   assign bp_inc    = idx_next(bp_ff);
   assign bp_dec    = idx_prev(bp_ff);
   assign bp_dec2   = idx_prev(bp_dec);

   deq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      fill_front_in = fill_front_ff;
      fp_in         = fp_ff;
      bp_in         = bp_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      popped_in     = popped_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = bp_ff;
      rd_en         = 1'b0;
      rd_addr       = fp_inc;
      load_rsp      = 1'b0;
      out_status    = deq_pkg::STATUS_OK;
      out_popped    = '0;
      out_pop_valid = 1'b0;

      if (req_fire) begin
         unique case (req_data.cmd)
            deq_pkg::CMD_PUSH_FRONT: begin
               if (q_full) begin
                  out_status = deq_pkg::STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = fp_dec;
                  fp_in    = fp_dec;
                  count_in = count_ff + 1'b1;
                  front_in = req_data.push_value;
                  if (q_empty) begin
                     back_in = req_data.push_value;
                  end
               end
            end
            deq_pkg::CMD_PUSH_BACK: begin
               if (q_full) begin
                  out_status = deq_pkg::STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = bp_ff;
                  bp_in    = bp_inc;
                  count_in = count_ff + 1'b1;
                  back_in  = req_data.push_value;
                  if (q_empty) begin
                     front_in = req_data.push_value;
                  end
               end
            end
            deq_pkg::CMD_POP_FRONT: begin
               if (q_empty) begin
                  out_status = deq_pkg::STATUS_EMPTY;
               end else begin
                  out_popped    = front_ff;
                  out_pop_valid = 1'b1;
                  popped_in     = front_ff;
                  fp_in         = fp_inc;
                  count_in      = count_ff - 1'b1;
                  if (count_ff != CW'(1)) begin
                     rd_en         = 1'b1;
                     rd_addr       = fp_inc;
                     fill_front_in = 1'b1;
                     state_in      = ST_FILL;
                  end
               end
            end
            deq_pkg::CMD_POP_BACK: begin
               if (q_empty) begin
                  out_status = deq_pkg::STATUS_EMPTY;
               end else begin
                  out_popped    = back_ff;
                  out_pop_valid = 1'b1;
                  popped_in     = back_ff;
                  bp_in         = bp_dec;
                  count_in      = count_ff - 1'b1;
                  if (count_ff != CW'(1)) begin
                     rd_en         = 1'b1;
                     rd_addr       = bp_dec2;
                     fill_front_in = 1'b0;
                     state_in      = ST_FILL;
                  end
               end
            end
            default: ;
         endcase
         load_rsp = (state_in == ST_IDLE);
      end else if ((state_ff == ST_FILL) && slot_free) begin
         if (fill_front_ff) begin
            front_in = rd_data;
         end else begin
            back_in = rd_data;
         end
         out_popped    = popped_ff;
         out_pop_valid = 1'b1;
         state_in      = ST_IDLE;
         load_rsp      = 1'b1;
      end

      out_empty = (count_in == '0);
      if (load_rsp) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.popped_value  = out_popped;
         rsp_data_in.pop_valid     = out_pop_valid;
         rsp_data_in.status        = out_status;
         rsp_data_in.count         = deq_pkg::COUNT_W'(count_in);
         rsp_data_in.is_empty      = out_empty;
         rsp_data_in.front_value   = out_empty ? '0 : front_in;
         rsp_data_in.back_value    = out_empty ? '0 : back_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fp_ff        <= '0;
         bp_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fp_ff        <= fp_in;
         bp_ff        <= bp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_front_ff <= fill_front_in;
      front_ff      <= front_in;
      back_ff       <= back_in;
      popped_ff     <= popped_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   `DEQ_ASSERT_NOW(a_ptr_empty, clock, reset, count_ff == '0, fp_ff == bp_ff)
   `DEQ_ASSERT_NEXT(a_fill_done, clock, reset, state_ff == ST_FILL && slot_free, state_ff == ST_IDLE && rsp_valid_ff)
   `DEQ_ASSERT_NEXT(a_empty_pop, clock, reset, req_fire && is_pop && q_empty, rsp_valid_ff && rsp_data_ff.status == deq_pkg::STATUS_EMPTY)

endmodule

`default_nettype wire

@@ sim/deq_checker.sv @@
module deq_checker #(
   parameter int DEPTH = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire deq_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire deq_pkg::rsp_type rsp_data,
   output int unsigned           outstanding,
   output int unsigned           queue_level,
   output int unsigned           mismatches
);

   localparam int REPORT_LIMIT = 10;

   logic signed [deq_pkg::DATA_W-1:0] shadow_store [DEPTH];
   int unsigned                       head_idx;
   int unsigned                       tail_idx;
   int unsigned                       fill;
   deq_pkg::rsp_type                  awaited_results [$];

   function automatic int unsigned wrap_inc(input int unsigned i);
      return (i + 1 >= DEPTH) ? 0 : i + 1;
   endfunction

   function automatic int unsigned wrap_dec(input int unsigned i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   function automatic deq_pkg::rsp_type step_deque(input deq_pkg::req_type cmd_beat);
      deq_pkg::rsp_type res;
      res = '0;
      res.status = deq_pkg::STATUS_OK;
      unique case (cmd_beat.cmd)
         deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               res.status = deq_pkg::STATUS_FULL;
            end else if (cmd_beat.cmd == deq_pkg::CMD_PUSH_FRONT) begin
               head_idx = wrap_dec(head_idx);
               shadow_store[head_idx] = cmd_beat.push_value;
               fill++;
            end else begin
               shadow_store[tail_idx] = cmd_beat.push_value;
               tail_idx = wrap_inc(tail_idx);
               fill++;
            end
         end
         deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
            if (fill == 0) begin
               res.status = deq_pkg::STATUS_EMPTY;
            end else if (cmd_beat.cmd == deq_pkg::CMD_POP_FRONT) begin
               res.popped_value = shadow_store[head_idx];
               res.pop_valid = 1'b1;
               head_idx = wrap_inc(head_idx);
               fill--;
            end else begin
               tail_idx = wrap_dec(tail_idx);
               res.popped_value = shadow_store[tail_idx];
               res.pop_valid = 1'b1;
               fill--;
            end
         end
         default: begin
         end
      endcase
      res.count = deq_pkg::COUNT_W'(fill);
      res.is_empty = (fill == 0);
      if (fill != 0) begin
         res.front_value = shadow_store[head_idx];
         res.back_value = shadow_store[wrap_dec(tail_idx)];
      end
      return res;
   endfunction

   function automatic void flag_mismatch(input string what, input logic signed [31:0] want,
                                         input logic signed [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch in %s: expected %0d, got %0d", what, want, got);
      end
   endfunction

   function automatic void check_result(input deq_pkg::rsp_type got);
      deq_pkg::rsp_type want;
      if (awaited_results.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected result beat: count %0d status %0d", got.count, got.status);
         end
         return;
      end
      want = awaited_results[0];
      awaited_results.delete(0);
      if (got.popped_value !== want.popped_value) begin
         flag_mismatch("popped_value", want.popped_value, got.popped_value);
      end
      if (got.pop_valid !== want.pop_valid) begin
         flag_mismatch("pop_valid", want.pop_valid, got.pop_valid);
      end
      if (got.status !== want.status) begin
         flag_mismatch("status", want.status, got.status);
      end
      if (got.count !== want.count) begin
         flag_mismatch("count", want.count, got.count);
      end
      if (got.is_empty !== want.is_empty) begin
         flag_mismatch("is_empty", want.is_empty, got.is_empty);
      end
      if (got.front_value !== want.front_value) begin
         flag_mismatch("front_value", want.front_value, got.front_value);
      end
      if (got.back_value !== want.back_value) begin
         flag_mismatch("back_value", want.back_value, got.back_value);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         head_idx = 0;
         tail_idx = 0;
         fill = 0;
         mismatches = 0;
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.insert(awaited_results.size(), step_deque(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
      end
      outstanding <= awaited_results.size();
      queue_level <= fill;
   end

endmodule

@@ sim/testbench.sv @@
module testbench;

   localparam int         QUEUE_DEPTH     = 1024;
   localparam int         IDLE_LIMIT      = 1000;
   localparam int         SQUEEZE_CYCLES  = 80;
   localparam int         DRAIN_CYCLES    = 20;
   localparam logic [2:0] CMD_SPARE_FIRST = deq_pkg::CMD_QUERY + 3'd1;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   deq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   deq_pkg::rsp_type rsp_data;
   int unsigned      outstanding;
   int unsigned      queue_level;
   int unsigned      mismatches;
   bit               sender_steady;

   double_ended_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   deq_checker #(
      .DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .outstanding(outstanding),
      .queue_level(queue_level),
      .mismatches(mismatches)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return 32'sh0;
         3: return -32'sd1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [2:0] pick_cmd(input int push_w, input int pop_w);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_w) begin
         return $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
      end
      if (r < push_w + pop_w) begin
         return $urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
      end
      if ($urandom_range(0, 3) != 0) return deq_pkg::CMD_QUERY;
      return 3'($urandom_range(int'(CMD_SPARE_FIRST), int'(CMD_SPARE_LAST)));
   endfunction

   task automatic send_beat(input logic [2:0] c, input logic signed [31:0] v);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: c, push_value: v};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic run_phase(input int items, input int push_w, input int pop_w,
                            input bit until_full);
      int n;
      n = 0;
      while (until_full ? (queue_level < QUEUE_DEPTH) : (n < items)) begin
         if (n % 50 == 0) sender_steady = ($urandom_range(0, 3) == 0);
         send_beat(pick_cmd(push_w, pop_w), pick_value());
         n++;
      end
      drain_results();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      sender_steady = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_beat(deq_pkg::CMD_QUERY, 32'sh1234_5678);
      send_beat(deq_pkg::CMD_POP_FRONT, 32'sh0);
      send_beat(deq_pkg::CMD_POP_BACK, -32'sd1);
      send_beat(deq_pkg::CMD_PUSH_FRONT, 32'sh7fff_ffff);
      send_beat(deq_pkg::CMD_PUSH_BACK, 32'sh8000_0000);
      send_beat(deq_pkg::CMD_QUERY, 32'sh0);
      send_beat(deq_pkg::CMD_POP_FRONT, 32'sh0);
      send_beat(deq_pkg::CMD_POP_BACK, 32'sh0);
      send_beat(deq_pkg::CMD_PUSH_BACK, -32'sd1);
      send_beat(deq_pkg::CMD_PUSH_FRONT, 32'sh0);
      send_beat(deq_pkg::CMD_PUSH_BACK, 32'sh1);
      send_beat(deq_pkg::CMD_PUSH_FRONT, 32'sh5555_5555);
      send_beat(deq_pkg::CMD_PUSH_BACK, 32'shaaaa_aaaa);
      send_beat(CMD_SPARE_FIRST, 32'sh7fff_ffff);
      send_beat(CMD_SPARE_FIRST + 3'd1, 32'sh8000_0000);
      send_beat(CMD_SPARE_LAST, -32'sd1);
      send_beat(deq_pkg::CMD_POP_BACK, 32'sh0);
      send_beat(deq_pkg::CMD_POP_FRONT, 32'sh0);
      send_beat(deq_pkg::CMD_POP_FRONT, 32'sh0);
      send_beat(deq_pkg::CMD_POP_BACK, 32'sh0);
      send_beat(deq_pkg::CMD_POP_BACK, 32'sh0);
      send_beat(deq_pkg::CMD_POP_FRONT, 32'sh0);
      send_beat(deq_pkg::CMD_POP_BACK, 32'sh0);
      drain_results();

      run_phase(250, 45, 45, 1'b0);
      // climb to full, then keep pushing against it
      run_phase(0, 93, 4, 1'b1);
      run_phase(40, 80, 10, 1'b0);
      run_phase(250, 20, 70, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      int hold;
      int quiet;
      quiet = 0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      // hold results back so the queue backs up into the input
      rsp_stall <= 1'b1;
      repeat (SQUEEZE_CYCLES) @(posedge clock);
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (quiet == 0 && $urandom_range(0, 199) == 0) quiet = $urandom_range(50, 200);
         if (quiet > 0) begin
            quiet--;
            hold = 0;
         end else begin
            hold = pick_gap();
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
